>>> design/kmae_pkg.sv
package kmae_pkg;

	localparam int MAX_CLUSTERS = 16;
	localparam int MAX_DIMS     = 4;
	localparam int MAX_POINTS   = 4096;
	localparam int COORD_BITS   = 16;
	localparam int COUNT_BITS   = 13;
	localparam int SUM_BITS     = COORD_BITS + 13;
	localparam int K_BITS       = $clog2(MAX_CLUSTERS);
	localparam int P_BITS       = $clog2(MAX_POINTS);
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int SQ_BITS      = 2 * DIFF_BITS;
	localparam int DIST_BITS    = 34;
	localparam int QUO_BITS     = SUM_BITS;

	localparam logic [2:0] MODE_LOAD     = 3'd0;
	localparam logic [2:0] MODE_ASSIGN   = 3'd1;
	localparam logic [2:0] MODE_REASSIGN = 3'd2;
	localparam logic [2:0] MODE_UPDATE   = 3'd3;
	localparam logic [2:0] MODE_CLEAR    = 3'd4;

	localparam logic [0:0] REG_CLUSTERS = 1'd0;
	localparam logic [0:0] REG_DIMS     = 1'd1;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef coord_t [MAX_DIMS-1:0] vec_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [11:0] index;
		coord_t      coord_3;
		coord_t      coord_2;
		coord_t      coord_1;
		coord_t      coord_0;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  cluster;
		logic [33:0] square_distance;
		logic        changed;
		logic [31:0] change_total;
		logic [12:0] member_count;
		coord_t      mean_0;
		coord_t      mean_1;
		coord_t      mean_2;
		coord_t      mean_3;
		logic        last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SEARCH, ST_SDONE, ST_UPD1, ST_UPD2, ST_UPD3,
		ST_UFETCH, ST_UDIV, ST_UEMIT, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [COUNT_BITS-1:0] divisor;
	} div_req_t;

endpackage

>>> design/kmae_dist_lane.sv
// one dimension: squared difference against one centroid coordinate
module kmae_dist_lane import kmae_pkg::*; (
	input  logic                clk,
	input  coord_t              mean,
	input  coord_t              point,
	input  logic                active,
	output logic [SQ_BITS-1:0]  sq_s1
);
	logic signed [DIFF_BITS-1:0] diff;
	logic signed [SQ_BITS-1:0]   prod;

	assign diff = DIFF_BITS'(mean) - DIFF_BITS'(point);
	assign prod = diff * diff;

	always_ff @(posedge clk) begin
		sq_s1 <= active ? prod : '0;
	end
endmodule

>>> design/kmae_divider.sv
// restoring signed divide, sum by count, one quotient bit per cycle
module kmae_divider import kmae_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  div_req_t                  req,
	input  logic [SUM_BITS-1:0]       dividend,
	output logic                      done,
	output coord_t                    result
);
	localparam int CNT_BITS = $clog2(QUO_BITS + 1);
	logic [QUO_BITS-1:0]   quo_q;
	logic [COUNT_BITS:0]   rem_q;
	logic [COUNT_BITS-1:0] dvs_q;
	logic                  neg_q, busy_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [COUNT_BITS+1:0] trial;
	logic [QUO_BITS:0]     sq;
	logic signed [QUO_BITS:0] sres;
	logic [SUM_BITS-1:0]   mag;

	assign mag   = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : dividend;
	assign trial = {rem_q, quo_q[QUO_BITS-1]} - {2'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(QUO_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= mag;
			rem_q <= '0;
			dvs_q <= req.divisor;
			neg_q <= dividend[SUM_BITS-1];
		end else if (busy_q) begin
			if (!trial[COUNT_BITS+1]) begin
				rem_q <= trial[COUNT_BITS:0];
				quo_q <= {quo_q[QUO_BITS-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[COUNT_BITS-1:0], quo_q[QUO_BITS-1]};
				quo_q <= {quo_q[QUO_BITS-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		sq   = {1'b0, quo_q};
		sres = neg_q ? -$signed(sq) : $signed(sq);
		if (sres > $signed((QUO_BITS+1)'((1 << (COORD_BITS-1)) - 1)))
			result = {1'b0, {(COORD_BITS-1){1'b1}}};
		else if (sres < -$signed((QUO_BITS+1)'(1 << (COORD_BITS-1))))
			result = {1'b1, {(COORD_BITS-1){1'b0}}};
		else
			result = coord_t'(sres[COORD_BITS-1:0]);
	end
endmodule

>>> design/kmeans_assign_update_engine.sv
// assign/reassign: centroids searched one per cycle through four lanes, then label, counts
// and sums updated and the result item registered; the next item is accepted after that
// update: per cluster, one bit-serial divide for each used dimension if its count is nonzero,
// then its result item is emitted; load and clear go straight back to idle via ST_UPD3
// output stalls add their cycles to the state that waits for the output register
// reset: control, counts, sums, means and change counter cleared at once; labels undefined
module kmeans_assign_update_engine import kmae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	// configuration registers
	logic [4:0] clusters_q;
	logic [2:0] dims_q;
	logic [K_BITS:0] nk;
	logic [2:0] nd;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clusters_q <= 5'd16;
			dims_q     <= 3'd4;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_CLUSTERS: clusters_q <= pwdata[4:0];
				REG_DIMS:     dims_q     <= pwdata[2:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[2])
			REG_CLUSTERS: prdata = {27'd0, clusters_q};
			REG_DIMS:     prdata = {29'd0, dims_q};
			default:      prdata = '0;
		endcase
	end
	always_comb begin
		nk = (clusters_q == 0) ? (K_BITS+1)'(1) :
		     (clusters_q > MAX_CLUSTERS) ? (K_BITS+1)'(MAX_CLUSTERS) : (K_BITS+1)'(clusters_q);
		nd = (dims_q == 0) ? 3'd1 : (dims_q > MAX_DIMS) ? 3'(MAX_DIMS) : dims_q;
	end

	// cluster state: small flop arrays, read at the centroid pointer, best or old cluster; labels per point
	vec_t                              means_q  [MAX_CLUSTERS];
	logic [MAX_DIMS-1:0][SUM_BITS-1:0] sums_q   [MAX_CLUSTERS];
	logic [COUNT_BITS-1:0]             counts_q [MAX_CLUSTERS];
	logic [31:0]                       chg_q;
	logic [K_BITS-1:0]                 labels_mem [MAX_POINTS];
	logic [K_BITS-1:0]                 label_rd_s1;

	state_t st_q, st_d;
	in_item_t item_q;
	logic [K_BITS:0] k_q;         // centroid pointer, also update cluster
	logic [K_BITS:0] kp_s1;       // centroid whose squares are in the lanes
	logic            kv_s1;
	logic [2:0]      d_q;
	logic [DIST_BITS-1:0] best_q;
	logic [K_BITS-1:0]    bk_q;
	logic            bvalid_q;
	vec_t pt, mean_cur;
	logic [MAX_DIMS-1:0][SQ_BITS-1:0] sq_s1;
	logic [DIST_BITS-1:0] dist_sum;
	out_item_t res_q;
	logic      rv_q;
	logic      accept;
	logic      out_free;
	div_req_t  dreq;
	logic      ddone;
	coord_t    dres;
	logic [SUM_BITS-1:0] dsum;
	vec_t      newmean_q;

	assign pt = {item_q.coord_3, item_q.coord_2, item_q.coord_1, item_q.coord_0};
	assign mean_cur = means_q[k_q[K_BITS-1:0]];
	assign out_free = !rv_q || !out_stall;
	assign in_stall = (st_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_valid = rv_q;
	assign out_data  = res_q;

	// dimension lanes
	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_lane
		kmae_dist_lane u_lane (
			.clk(clk), .mean(mean_cur[g]), .point(pt[g]),
			.active(3'(g) < nd), .sq_s1(sq_s1[g])
		);
	end

	// merge: add lane squares and keep running minimum
	always_comb begin
		dist_sum = '0;
		for (int i = 0; i < MAX_DIMS; i++) dist_sum = dist_sum + DIST_BITS'(sq_s1[i]);
	end

	assign dsum = sums_q[k_q[K_BITS-1:0]][d_q[1:0]];
	kmae_divider u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .dividend(dsum),
		.done(ddone), .result(dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else         st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		dreq.start   = 1'b0;
		dreq.divisor = counts_q[k_q[K_BITS-1:0]];
		case (st_q)
			ST_IDLE: if (accept) begin
				if (in_data.mode == MODE_ASSIGN || in_data.mode == MODE_REASSIGN)
					st_d = ST_SEARCH;
				else if (in_data.mode == MODE_UPDATE) st_d = ST_UFETCH;
				else st_d = ST_UPD3;
			end
			ST_SEARCH: if (k_q + 1'b1 == nk) st_d = ST_SDONE;
			ST_SDONE:  st_d = ST_UPD1;
			ST_UPD1:   st_d = ST_UPD2;
			ST_UPD2:   st_d = ST_OUT;
			ST_OUT:    if (out_free) st_d = ST_UPD3;
			ST_UPD3:   st_d = ST_IDLE;
			ST_UFETCH: begin
				if (counts_q[k_q[K_BITS-1:0]] != 0 && d_q < nd) begin
					dreq.start = 1'b1;
					st_d = ST_UDIV;
				end else st_d = ST_UEMIT;
			end
			ST_UDIV: if (ddone) st_d = ST_UFETCH;
			ST_UEMIT: if (out_free) st_d = (k_q + 1'b1 == nk) ? ST_UPD3 : ST_UFETCH;
			default: st_d = ST_IDLE;
		endcase
	end

	// label memory, registered read
	always_ff @(posedge clk) begin
		label_rd_s1 <= labels_mem[item_q.index[P_BITS-1:0]];
		if (st_q == ST_UPD1 && item_q.mode == MODE_ASSIGN)
			labels_mem[item_q.index[P_BITS-1:0]] <= bk_q;
		else if (st_q == ST_UPD2 && item_q.mode == MODE_REASSIGN && label_rd_s1 != bk_q)
			labels_mem[item_q.index[P_BITS-1:0]] <= bk_q;
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= in_data;
		kp_s1 <= k_q;
		kv_s1 <= (st_q == ST_SEARCH);
		if (ddone) newmean_q[d_q[1:0]] <= dres;
	end

	logic moved;
	logic moved_q;               // reassign moved the point, held for the result item
	logic [K_BITS-1:0] old;
	assign old   = label_rd_s1;
	assign moved = (old != bk_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CLUSTERS; i++) begin
				means_q[i]  <= '0;
				sums_q[i]   <= '0;
				counts_q[i] <= '0;
			end
			chg_q    <= '0;
			k_q      <= '0;
			d_q      <= '0;
			bvalid_q <= 1'b0;
			best_q   <= '0;
			bk_q     <= '0;
			rv_q     <= 1'b0;
			res_q    <= '0;
			moved_q  <= 1'b0;
		end else begin
			// emitting states reload the output register themselves
			if (rv_q && !out_stall && st_q != ST_OUT && st_q != ST_UEMIT) rv_q <= 1'b0;
			// running minimum over lane results, lowest index wins ties
			if (kv_s1 && (!bvalid_q || dist_sum < best_q)) begin
				best_q   <= dist_sum;
				bk_q     <= kp_s1[K_BITS-1:0];
				bvalid_q <= 1'b1;
			end
			case (st_q)
				ST_IDLE: if (accept) begin
					k_q <= '0;
					d_q <= '0;
					bvalid_q <= 1'b0;
					if (in_data.mode == MODE_LOAD && in_data.index < MAX_CLUSTERS)
						means_q[in_data.index[K_BITS-1:0]] <=
							{in_data.coord_3, in_data.coord_2, in_data.coord_1, in_data.coord_0};
					if (in_data.mode == MODE_CLEAR) begin
						for (int i = 0; i < MAX_CLUSTERS; i++) begin
							sums_q[i]   <= '0;
							counts_q[i] <= '0;
						end
						chg_q <= '0;
					end
				end
				ST_SEARCH: if (k_q + 1'b1 != nk) k_q <= k_q + 1'b1;
				ST_UPD1: if (item_q.mode == MODE_ASSIGN) begin
					counts_q[bk_q] <= counts_q[bk_q] + 1'b1;
					for (int d = 0; d < MAX_DIMS; d++)
						if (3'(d) < nd)
							sums_q[bk_q][d] <= sums_q[bk_q][d] + SUM_BITS'(pt[d]);
				end
				ST_UPD2: begin
					moved_q <= (item_q.mode == MODE_REASSIGN) && moved;
					if (item_q.mode == MODE_REASSIGN && moved) begin
						if (chg_q != 32'hFFFF_FFFF) chg_q <= chg_q + 1'b1;
						counts_q[bk_q] <= counts_q[bk_q] + 1'b1;
						for (int d = 0; d < MAX_DIMS; d++)
							if (3'(d) < nd)
								sums_q[bk_q][d] <= sums_q[bk_q][d] + SUM_BITS'(pt[d]);
						if (counts_q[old] != 0) begin
							counts_q[old] <= counts_q[old] - 1'b1;
							for (int d = 0; d < MAX_DIMS; d++)
								if (3'(d) < nd)
									sums_q[old][d] <= sums_q[old][d] - SUM_BITS'(pt[d]);
						end
					end
				end
				ST_OUT: if (out_free) begin
					rv_q <= 1'b1;
					res_q.cluster <= 4'(bk_q);
					res_q.square_distance <= best_q;
					res_q.changed <= moved_q;
					res_q.change_total <= chg_q;
					res_q.member_count <= '0;
					res_q.mean_0 <= '0;
					res_q.mean_1 <= '0;
					res_q.mean_2 <= '0;
					res_q.mean_3 <= '0;
					res_q.last <= 1'b1;
				end
				ST_UDIV: if (ddone) d_q <= d_q + 1'b1;
				ST_UEMIT: if (out_free) begin
					if (counts_q[k_q[K_BITS-1:0]] != 0) begin
						for (int d = 0; d < MAX_DIMS; d++)
							if (3'(d) < nd) means_q[k_q[K_BITS-1:0]][d] <= newmean_q[d];
					end
					rv_q <= 1'b1;
					res_q.cluster <= 4'(k_q);
					res_q.square_distance <= '0;
					res_q.changed <= 1'b0;
					res_q.change_total <= chg_q;
					res_q.member_count <= counts_q[k_q[K_BITS-1:0]];
					if (counts_q[k_q[K_BITS-1:0]] != 0) begin
						res_q.mean_0 <= (nd > 0) ? newmean_q[0] : mean_cur[0];
						res_q.mean_1 <= (nd > 1) ? newmean_q[1] : mean_cur[1];
						res_q.mean_2 <= (nd > 2) ? newmean_q[2] : mean_cur[2];
						res_q.mean_3 <= (nd > 3) ? newmean_q[3] : mean_cur[3];
					end else begin
						res_q.mean_0 <= mean_cur[0];
						res_q.mean_1 <= mean_cur[1];
						res_q.mean_2 <= mean_cur[2];
						res_q.mean_3 <= mean_cur[3];
					end
					res_q.last <= (k_q + 1'b1 == nk);
					k_q <= k_q + 1'b1;
					d_q <= '0;
				end
				default: ;
			endcase
		end
	end
endmodule

>>> verif/tb.sv
module tb;
	import kmae_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	kmeans_assign_update_engine DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// model state of the engine
	logic signed [15:0] cent [MAX_CLUSTERS][MAX_DIMS];
	logic [28:0]        sum_acc [MAX_CLUSTERS][MAX_DIMS];
	logic [12:0]        members [MAX_CLUSTERS];
	logic [3:0]         label_of [MAX_POINTS];
	bit                 label_set [MAX_POINTS];
	logic [31:0]        moves;
	int                 k_used = 16;
	int                 d_used = 4;

	out_item_t expected_q [$];
	int        errors = 0;
	int        idle_cycles = 0;
	bit        hold_rx = 1'b0;
	bit        rand_rx = 1'b1;

	function automatic int clamp_k(int v);
		return (v == 0) ? 1 : (v > MAX_CLUSTERS ? MAX_CLUSTERS : v);
	endfunction

	function automatic int clamp_d(int v);
		return (v == 0) ? 1 : (v > MAX_DIMS ? MAX_DIMS : v);
	endfunction

	// queue one expected result item behind the others
	function automatic void expect_result(out_item_t r);
		expected_q.insert(expected_q.size(), r);
	endfunction

	function automatic void move_sum(int k, in_item_t it, bit sub);
		logic signed [15:0] pt [4];
		logic [28:0] v;
		pt = '{it.coord_0, it.coord_1, it.coord_2, it.coord_3};
		for (int d = 0; d < d_used; d++) begin
			v = 29'(signed'(pt[d]));
			sum_acc[k][d] = sub ? sum_acc[k][d] - v : sum_acc[k][d] + v;
		end
	endfunction

	// predict the results of one accepted item
	function automatic void predict_clustering(in_item_t it);
		logic signed [15:0] pt [4];
		longint sqd, best, diff, q;
		int nk, old, p;
		out_item_t r;
		pt = '{it.coord_0, it.coord_1, it.coord_2, it.coord_3};
		case (it.mode)
			MODE_LOAD: if (it.index < MAX_CLUSTERS)
				for (int d = 0; d < MAX_DIMS; d++) cent[it.index][d] = pt[d];
			MODE_CLEAR: begin
				for (int k = 0; k < MAX_CLUSTERS; k++) begin
					members[k] = '0;
					for (int d = 0; d < MAX_DIMS; d++) sum_acc[k][d] = '0;
				end
				moves = '0;
			end
			MODE_ASSIGN, MODE_REASSIGN: begin
				p = int'(it.index);
				nk = 0;
				best = 0;
				for (int k = 0; k < k_used; k++) begin
					sqd = 0;
					for (int d = 0; d < d_used; d++) begin
						diff = longint'(cent[k][d]) - longint'(pt[d]);
						sqd += diff * diff;
					end
					if (k == 0 || sqd < best) begin
						best = sqd;
						nk = k;
					end
				end
				r = '0;
				if (it.mode == MODE_ASSIGN) begin
					label_of[p] = 4'(nk);
					label_set[p] = 1'b1;
					members[nk] += 1;
					move_sum(nk, it, 1'b0);
				end else begin
					old = int'(label_of[p]);
					if (old != nk) begin
						r.changed = 1'b1;
						if (moves != 32'hFFFF_FFFF) moves += 1;
						label_of[p] = 4'(nk);
						members[nk] += 1;
						move_sum(nk, it, 1'b0);
						if (members[old] != 0) begin
							members[old] -= 1;
							move_sum(old, it, 1'b1);
						end
					end
				end
				r.cluster = 4'(nk);
				r.square_distance = best[33:0];
				r.change_total = moves;
				r.last = 1'b1;
				expect_result(r);
			end
			MODE_UPDATE: for (int k = 0; k < k_used; k++) begin
				if (members[k] != 0)
					for (int d = 0; d < d_used; d++) begin
						q = longint'(signed'(sum_acc[k][d])) / longint'(members[k]);
						if (q > 32767) q = 32767;
						if (q < -32768) q = -32768;
						cent[k][d] = q[15:0];
					end
				r = '0;
				r.cluster = 4'(k);
				r.change_total = moves;
				r.member_count = members[k];
				r.mean_0 = cent[k][0];
				r.mean_1 = cent[k][1];
				r.mean_2 = cent[k][2];
				r.mean_3 = cent[k][3];
				r.last = (k + 1 == k_used);
				expect_result(r);
			end
			default: ;
		endcase
	endfunction

	// receiver stall: random, held off for a long stretch, or never stalled
	always @(posedge clk) begin
		if (hold_rx) out_stall <= 1'b1;
		else if (rand_rx) out_stall <= ($urandom_range(0, 3) == 0);
		else out_stall <= 1'b0;
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result item %p", out_data);
				errors++;
			end else begin
				automatic out_item_t e = expected_q.pop_front();
				if (e.cluster !== out_data.cluster) begin
					$error("cluster exp %0d got %0d", e.cluster, out_data.cluster);
					errors++;
				end
				if (e.square_distance !== out_data.square_distance) begin
					$error("square_distance exp %0d got %0d", e.square_distance,
						out_data.square_distance);
					errors++;
				end
				if (e.changed !== out_data.changed) begin
					$error("changed exp %0d got %0d", e.changed, out_data.changed);
					errors++;
				end
				if (e.change_total !== out_data.change_total) begin
					$error("change_total exp %0d got %0d", e.change_total,
						out_data.change_total);
					errors++;
				end
				if (e.member_count !== out_data.member_count) begin
					$error("member_count exp %0d got %0d", e.member_count,
						out_data.member_count);
					errors++;
				end
				if (e.mean_0 !== out_data.mean_0) begin
					$error("mean_0 exp %0d got %0d", e.mean_0, out_data.mean_0);
					errors++;
				end
				if (e.mean_1 !== out_data.mean_1) begin
					$error("mean_1 exp %0d got %0d", e.mean_1, out_data.mean_1);
					errors++;
				end
				if (e.mean_2 !== out_data.mean_2) begin
					$error("mean_2 exp %0d got %0d", e.mean_2, out_data.mean_2);
					errors++;
				end
				if (e.mean_3 !== out_data.mean_3) begin
					$error("mean_3 exp %0d got %0d", e.mean_3, out_data.mean_3);
					errors++;
				end
				if (e.last !== out_data.last) begin
					$error("last exp %0d got %0d", e.last, out_data.last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no accepted item on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one item and wait until it is taken
	task automatic send_item(in_item_t it, bit gaps = 1'b1);
		int gap;
		gap = gaps ? int'($urandom_range(0, 9)) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		// valid always drops between items, the engine stalls after each accepted one anyway
		if (gap == 0) gap = 1;
		repeat (gap) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_clustering(it);
		in_valid <= 1'b0;
	endtask

	task automatic drain;
		while (expected_q.size() != 0) @(posedge clk);
		// load and clear items leave no result behind them
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, int value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		if (idx == REG_CLUSTERS) k_used = clamp_k(value & 31);
		else d_used = clamp_d(value & 7);
	endtask

	function automatic in_item_t make_item(logic [2:0] m, int idx, int c0, int c1, int c2,
			int c3);
		in_item_t it;
		it.mode = m;
		it.index = 12'(idx);
		it.coord_0 = 16'(c0);
		it.coord_1 = 16'(c1);
		it.coord_2 = 16'(c2);
		it.coord_3 = 16'(c3);
		return it;
	endfunction

	function automatic int rnd_coord;
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			2: return int'($urandom_range(0, 200)) - 100;
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// point number that already has a label, for reassigns; point 0 if none is found
	function automatic int labeled_point;
		for (int t = 0; t < 50; t++) begin
			automatic int p = $urandom_range(0, 4095);
			if (label_set[p]) return p;
		end
		return 0;
	endfunction

	task automatic test_directed;
		send_item(make_item(MODE_ASSIGN, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_UPDATE, 0, 0, 0, 0, 0));
		send_item(make_item(MODE_LOAD, 1, 32767, 32767, 32767, 32767));
		send_item(make_item(MODE_LOAD, 2, -32768, -32768, -32768, -32768));
		send_item(make_item(MODE_LOAD, 4095, 5, 5, 5, 5));
		send_item(make_item(MODE_LOAD, 16, 7, 7, 7, 7));
		// extreme distance and ties with the lowest cluster winning
		send_item(make_item(MODE_ASSIGN, 4095, -32768, -32768, -32768, -32768));
		send_item(make_item(MODE_ASSIGN, 1, 32767, 32767, 32767, 32767));
		send_item(make_item(MODE_ASSIGN, 2, 0, 0, 0, 0));
		send_item(make_item(MODE_LOAD, 3, 100, 0, 0, 0));
		// reassign away from a cluster, repeat with no move, then empty a cluster
		send_item(make_item(MODE_REASSIGN, 2, 90, 0, 0, 0));
		send_item(make_item(MODE_REASSIGN, 2, 90, 0, 0, 0));
		send_item(make_item(MODE_REASSIGN, 4095, 1, 0, 0, 0));
		send_item(make_item(MODE_UPDATE, 0, 0, 0, 0, 0));
		send_item(make_item(3'd5, 7, 1, 2, 3, 4));
		send_item(make_item(3'd7, 4095, -1, -1, -1, -1));
		send_item(make_item(MODE_CLEAR, 0, 0, 0, 0, 0));
		// removal from a cluster that is already empty
		send_item(make_item(MODE_REASSIGN, 1, -30000, 0, 0, 0));
		send_item(make_item(MODE_UPDATE, 0, 0, 0, 0, 0));
		drain();
	endtask

	task automatic test_config_extremes;
		write_reg(REG_CLUSTERS, 1);
		write_reg(REG_DIMS, 1);
		send_item(make_item(MODE_ASSIGN, 10, 300, -7, 9, 9));
		send_item(make_item(MODE_UPDATE, 0, 0, 0, 0, 0));
		drain();
		write_reg(REG_CLUSTERS, 0);
		write_reg(REG_DIMS, 0);
		send_item(make_item(MODE_ASSIGN, 11, -5, 1, 1, 1));
		send_item(make_item(MODE_UPDATE, 0, 0, 0, 0, 0));
		drain();
		write_reg(REG_CLUSTERS, 31);
		write_reg(REG_DIMS, 7);
		send_item(make_item(MODE_ASSIGN, 12, 4, 4, 4, 4));
		drain();
	endtask

	// rounds: optional clear, load centroids, assign, reassign mixed with stray items, update, with random settings
	task automatic test_random_rounds;
		int sent;
		int p;
		sent = 0;
		while (sent < 400) begin
			write_reg(REG_CLUSTERS, $urandom_range(1, 16));
			write_reg(REG_DIMS, $urandom_range(1, 4));
			if ($urandom_range(0, 1)) begin
				send_item(make_item(MODE_CLEAR, $urandom_range(0, 4095), 0, 0, 0, 0));
				sent++;
			end
			for (int k = 0; k < k_used; k++) begin
				send_item(make_item(MODE_LOAD, k, rnd_coord(), rnd_coord(), rnd_coord(),
					rnd_coord()));
				sent++;
			end
			repeat ($urandom_range(5, 25)) begin
				p = $urandom_range(0, 4095);
				send_item(make_item(MODE_ASSIGN, p, rnd_coord(), rnd_coord(), rnd_coord(),
					rnd_coord()));
				sent++;
			end
			repeat ($urandom_range(3, 12)) begin
				case ($urandom_range(0, 9))
					0: send_item(make_item(3'($urandom_range(5, 7)), $urandom_range(0, 4095),
						rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()));
					1: send_item(make_item(MODE_LOAD, $urandom_range(0, 4095), rnd_coord(),
						rnd_coord(), rnd_coord(), rnd_coord()));
					default: send_item(make_item(MODE_REASSIGN, labeled_point(),
						rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()));
				endcase
				sent++;
			end
			send_item(make_item(MODE_UPDATE, $urandom_range(0, 4095), rnd_coord(),
				rnd_coord(), rnd_coord(), rnd_coord()));
			sent++;
			drain();
		end
	endtask

	// receiver holds off while the sender keeps offering items, then takes every result
	task automatic test_backpressure;
		write_reg(REG_CLUSTERS, 16);
		write_reg(REG_DIMS, 4);
		hold_rx = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_rx = 1'b0;
			end
			for (int i = 0; i < 12; i++)
				send_item(make_item(i % 3 == 2 ? MODE_UPDATE : MODE_ASSIGN,
					$urandom_range(0, 4095), rnd_coord(), rnd_coord(), rnd_coord(),
					rnd_coord()), 1'b0);
		join
		rand_rx = 1'b0;
		repeat (10)
			send_item(make_item(MODE_ASSIGN, $urandom_range(0, 4095), rnd_coord(),
				rnd_coord(), rnd_coord(), rnd_coord()), 1'b0);
		rand_rx = 1'b1;
		drain();
	endtask

	initial begin
		for (int k = 0; k < MAX_CLUSTERS; k++) begin
			members[k] = '0;
			for (int d = 0; d < MAX_DIMS; d++) begin
				cent[k][d] = '0;
				sum_acc[k][d] = '0;
			end
		end
		for (int p = 0; p < MAX_POINTS; p++) begin
			label_of[p] = '0;
			label_set[p] = 1'b0;
		end
		moves = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_backpressure();
		test_random_rounds();
		drain();
		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
